[hw/rtl/lcd_pkg.sv]
// Shared types and codes for the least-connections dispatcher.
// Has no dependencies; lcd_seq, the top level and the testbench import it.
package lcd_pkg;

  localparam int STATUS_W  = 2;
  localparam int WORKER_W  = 6;
  localparam int CONN_W    = 32;
  localparam int LOAD_W    = 16;
  localparam int STRAT_W   = 2;
  localparam int ACTIVE_W  = 7;
  localparam int REG_IDX_W = 2;
  localparam int CFG_W     = 7;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd8;
  localparam logic [LOAD_W-1:0]   LOAD_MAX     = 16'hFFFF;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DISABLED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

  localparam logic OP_DISPATCH = 1'b0;
  localparam logic OP_RELEASE  = 1'b1;

  localparam logic [STRAT_W-1:0] STRAT_LEAST = 2'd0;
  localparam logic [STRAT_W-1:0] STRAT_RR    = 2'd1;
  localparam logic [STRAT_W-1:0] STRAT_ZERO  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_STRATEGY = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ENABLE   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ACTIVE   = 2'd2;

  typedef struct packed {
    logic [STRAT_W-1:0]  strategy;
    logic                enable;
    logic [ACTIVE_W-1:0] active_workers;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORKER_W-1:0] chosen_worker;
    logic [CONN_W-1:0]   conn_out;
    logic [LOAD_W-1:0]   worker_load;
  } res_t;

endpackage

[hw/rtl/lcd_count_mem.sv]
// Load counter store: one write port, one registered read port.
// Per-entry valid bits make every counter read as zero after reset.
module lcd_count_mem #(
  parameter int DEPTH  = 8,
  parameter int DATA_W = 16,
  localparam int ADDR_W = $clog2(DEPTH > 1 ? DEPTH : 2)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

[hw/rtl/lcd_seq.sv]
// Dispatch sequencer: scans the counter store through one shared compare,
// picks a worker and writes the saturated counter back. Uses lcd_pkg.
module lcd_seq #(
  parameter int NUM_WORKERS = 8,
  parameter int COUNT_BITS  = 16,
  localparam int IDX_W = $clog2(NUM_WORKERS > 1 ? NUM_WORKERS : 2)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lcd_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic [lcd_pkg::CONN_W-1:0]    conn_id,
  input  logic [lcd_pkg::WORKER_W-1:0]  release_worker,
  output logic                          rd_en,
  output logic [IDX_W-1:0]              rd_addr,
  input  logic [COUNT_BITS-1:0]         rd_data,
  output logic                          wr_en,
  output logic [IDX_W-1:0]              wr_addr,
  output logic [COUNT_BITS-1:0]         wr_data,
  input  logic                          res_ready,
  output logic                          res_valid,
  output lcd_pkg::res_t                 res
);

  import lcd_pkg::*;

  localparam int RPT_W = (COUNT_BITS > LOAD_W) ? COUNT_BITS : LOAD_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_ISSUE, S_FIN} state_t;

  state_t                  state;
  logic [IDX_W-1:0]        rr_ptr;
  logic [IDX_W-1:0]        last_least;
  logic [IDX_W-1:0]        scan_i;
  logic [IDX_W-1:0]        cmp_idx;
  logic                    cmp_vld;
  logic [IDX_W-1:0]        best0;
  logic [COUNT_BITS-1:0]   b0_cnt;
  logic [COUNT_BITS-1:0]   min_cnt;
  logic [IDX_W-1:0]        min_idx;
  logic [IDX_W-1:0]        target;
  logic                    is_least;
  logic                    skip_wr;
  logic [STATUS_W-1:0]     pre_status;
  logic                    op_q;
  logic [CONN_W-1:0]       conn_q;
  logic [WORKER_W-1:0]     rel_q;

  logic [ACTIVE_W-1:0]     w;
  logic [IDX_W-1:0]        rr_idx;
  logic [ACTIVE_W-1:0]     rr_inc;
  logic [IDX_W-1:0]        rr_next;
  logic [IDX_W-1:0]        best0_next;
  logic [COUNT_BITS-1:0]   cnt_cur;
  logic [COUNT_BITS-1:0]   new_cnt;
  logic [IDX_W-1:0]        chosen;
  logic [RPT_W-1:0]        rpt_ext;
  logic [LOAD_W-1:0]       rpt_load;

  // Worker count clamped to 1..NUM_WORKERS.
  always_comb begin
    if (cfg.active_workers == '0) begin
      w = ACTIVE_W'(1);
    end else if (cfg.active_workers > ACTIVE_W'(NUM_WORKERS)) begin
      w = ACTIVE_W'(NUM_WORKERS);
    end else begin
      w = cfg.active_workers;
    end
  end

  always_comb begin
    rr_idx     = (ACTIVE_W'(rr_ptr) < w) ? rr_ptr : '0;
    rr_inc     = ACTIVE_W'(rr_idx) + ACTIVE_W'(1);
    rr_next    = (rr_inc >= w) ? '0 : rr_inc[IDX_W-1:0];
    best0_next = (ACTIVE_W'(last_least) < w) ? last_least : '0;
  end

  // The previous winner keeps its place unless some worker is strictly lower;
  // otherwise the lowest index holding the minimum wins.
  always_comb begin
    cnt_cur = is_least ? min_cnt : rd_data;
    chosen  = is_least ? ((b0_cnt == min_cnt) ? best0 : min_idx) : target;
    if (op_q == OP_RELEASE) begin
      new_cnt = (cnt_cur == '0) ? cnt_cur : cnt_cur - COUNT_BITS'(1);
    end else begin
      new_cnt = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + COUNT_BITS'(1);
    end
    rpt_ext  = RPT_W'(new_cnt);
    rpt_load = (rpt_ext > RPT_W'(LOAD_MAX)) ? LOAD_MAX : rpt_ext[LOAD_W-1:0];
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    rd_en     = (state == S_SCAN) || (state == S_ISSUE);
    rd_addr   = (state == S_SCAN) ? scan_i : target;
    res_valid = (state == S_FIN) && res_ready;
    wr_en     = res_valid && !skip_wr;
    wr_addr   = chosen;
    wr_data   = new_cnt;
    res.status = skip_wr ? pre_status : ST_OK;
    if (op_q == OP_RELEASE) begin
      res.chosen_worker = rel_q;
    end else begin
      res.chosen_worker = skip_wr ? '0 : WORKER_W'(chosen);
    end
    res.conn_out    = (op_q == OP_DISPATCH && !skip_wr) ? conn_q : '0;
    res.worker_load = skip_wr ? '0 : rpt_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rr_ptr     <= '0;
      last_least <= '0;
      cmp_vld    <= 1'b0;
    end else begin
      cmp_vld <= (state == S_SCAN);
      cmp_idx <= scan_i;
      if (cmp_vld) begin
        if (cmp_idx == '0 || rd_data < min_cnt) begin
          min_cnt <= rd_data;
          min_idx <= cmp_idx;
        end
        if (cmp_idx == best0) begin
          b0_cnt <= rd_data;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q     <= opcode;
            conn_q   <= conn_id;
            rel_q    <= release_worker;
            is_least <= 1'b0;
            skip_wr  <= 1'b0;
            if (opcode == OP_DISPATCH) begin
              if (!cfg.enable) begin
                skip_wr    <= 1'b1;
                pre_status <= ST_DISABLED;
                state      <= S_FIN;
              end else begin
                unique case (cfg.strategy)
                  STRAT_LEAST: begin
                    is_least <= 1'b1;
                    best0    <= best0_next;
                    scan_i   <= '0;
                    state    <= S_SCAN;
                  end
                  STRAT_RR: begin
                    target <= rr_idx;
                    rr_ptr <= rr_next;
                    state  <= S_ISSUE;
                  end
                  default: begin
                    target <= '0;
                    state  <= S_ISSUE;
                  end
                endcase
              end
            end else if (ACTIVE_W'(release_worker) >= w) begin
              skip_wr    <= 1'b1;
              pre_status <= ST_RANGE;
              state      <= S_FIN;
            end else begin
              target <= release_worker[IDX_W-1:0];
              state  <= S_ISSUE;
            end
          end
        end
        S_SCAN: begin
          if (ACTIVE_W'(scan_i) == w - ACTIVE_W'(1)) begin
            state <= S_DRAIN;
          end else begin
            scan_i <= scan_i + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          state <= S_FIN;
        end
        S_ISSUE: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (res_ready) begin
            if (is_least && !skip_wr) begin
              last_least <= chosen;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_wr_with_result: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> res_valid)
    else $error("counter written without a result");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready again right after an accepted item");

  a_no_write_on_error: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status != ST_OK) |-> !wr_en)
    else $error("counter changed by a rejected item");

  a_drain_has_data: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |-> cmp_vld)
    else $error("scan drained without a pending compare");

endmodule

[hw/rtl/least_connections_dispatcher.sv]
// Least-connections dispatcher. Least mode: the scan covers W counters
// (W = clamped active_workers), one counter read per cycle, then S_DRAIN and S_FIN.
// Round robin, worker zero and release pass through S_ISSUE; rejected items go to S_FIN.
// One item at a time; the next item is taken the cycle after the result is
// registered, while that result may still wait at the output.
// Synchronous reset clears counters (valid bits) and pointers and sets config to its defaults.
module least_connections_dispatcher #(
  parameter int NUM_WORKERS = 8,
  parameter int COUNT_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [lcd_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [lcd_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           opcode,
  input  logic [lcd_pkg::CONN_W-1:0]     conn_id,
  input  logic [lcd_pkg::WORKER_W-1:0]   release_worker,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lcd_pkg::STATUS_W-1:0]   status,
  output logic [lcd_pkg::WORKER_W-1:0]   chosen_worker,
  output logic [lcd_pkg::CONN_W-1:0]     conn_out,
  output logic [lcd_pkg::LOAD_W-1:0]     worker_load
);

  import lcd_pkg::*;

  localparam int IDX_W = $clog2(NUM_WORKERS > 1 ? NUM_WORKERS : 2);

  cfg_t                  cfg;
  res_t                  res;
  logic                  res_valid;
  logic                  res_ready;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [COUNT_BITS-1:0] rd_data;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [COUNT_BITS-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.strategy       <= STRAT_LEAST;
      cfg.enable         <= 1'b0;
      cfg.active_workers <= ACTIVE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STRATEGY: cfg.strategy       <= cfg_data[STRAT_W-1:0];
        REG_ENABLE:   cfg.enable         <= cfg_data[0];
        REG_ACTIVE:   cfg.active_workers <= cfg_data[ACTIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // The output register frees the sequencer as soon as its result is taken.
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      status        <= res.status;
      chosen_worker <= res.chosen_worker;
      conn_out      <= res.conn_out;
      worker_load   <= res.worker_load;
    end
  end

  lcd_count_mem #(
    .DEPTH  (NUM_WORKERS),
    .DATA_W (COUNT_BITS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  lcd_seq #(
    .NUM_WORKERS (NUM_WORKERS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .conn_id        (conn_id),
    .release_worker (release_worker),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .res_ready      (res_ready),
    .res_valid      (res_valid),
    .res            (res)
  );

endmodule

[tb/sv/tb_least_connections_dispatcher.sv]
// Self-checking testbench for the least-connections dispatcher: a directed table
// and random phases, checked against a local predictor or the table's fixed results.
// Depends on lcd_pkg and least_connections_dispatcher.
`timescale 1ns / 1ps

module tb_least_connections_dispatcher;
  import lcd_pkg::*;

  localparam int WORKERS       = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 300;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 75;

  // Strategy code with no mode of its own; the block treats it as worker zero.
  localparam logic [STRAT_W-1:0] STRAT_SPARE = 2'd3;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic [CFG_W-1:0]      reg_val;
    logic                  op;
    logic [CONN_W-1:0]     conn;
    logic [WORKER_W-1:0]   rel;
    bit                    fixed;
    res_t                  want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  opcode = OP_DISPATCH;
  logic [CONN_W-1:0]     conn_id = '0;
  logic [WORKER_W-1:0]   release_worker = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [WORKER_W-1:0]   chosen_worker;
  logic [CONN_W-1:0]     conn_out;
  logic [LOAD_W-1:0]     worker_load;

  // Predictor state.
  logic [LOAD_W-1:0]     load_cnt [WORKERS];
  logic [WORKER_W-1:0]   rr_next;
  logic [WORKER_W-1:0]   least_prev;
  cfg_t                  model_cfg;

  res_t                  pending_results [$];
  plan_row_t             plan [$];
  int                    mismatch_count = 0;
  int                    results_seen = 0;
  int                    idle_cycles = 0;
  int                    burst_left = 0;
  bit                    no_gaps = 1'b0;
  bit                    hold_done = 1'b0;

  always #4 clk = ~clk;

  least_connections_dispatcher #(
    .NUM_WORKERS(WORKERS),
    .COUNT_BITS (LOAD_W)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .conn_id       (conn_id),
    .release_worker(release_worker),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .chosen_worker (chosen_worker),
    .conn_out      (conn_out),
    .worker_load   (worker_load)
  );

  function automatic int worker_span();
    int span;
    span = int'(model_cfg.active_workers);
    if (span < 1) span = 1;
    if (span > WORKERS) span = WORKERS;
    return span;
  endfunction

  // Works out the result of one item and applies its effect on the counters.
  function automatic res_t predict_outcome(input logic op, input logic [CONN_W-1:0] conn,
                                           input logic [WORKER_W-1:0] rel);
    res_t r;
    int   span;
    int   pick;
    r = '0;
    span = worker_span();
    if (op == OP_DISPATCH) begin
      if (!model_cfg.enable) begin
        r.status = ST_DISABLED;
        return r;
      end
      case (model_cfg.strategy)
        STRAT_LEAST: begin
          // Start from the previous winner; only a strictly smaller count wins.
          pick = (int'(least_prev) < span) ? int'(least_prev) : 0;
          for (int i = 0; i < span; i++) begin
            if (load_cnt[i] < load_cnt[pick]) pick = i;
          end
          least_prev = WORKER_W'(pick);
        end
        STRAT_RR: begin
          pick = (int'(rr_next) < span) ? int'(rr_next) : 0;
          rr_next = (pick + 1 >= span) ? '0 : WORKER_W'(pick + 1);
        end
        default: pick = 0;
      endcase
      if (load_cnt[pick] != LOAD_MAX) load_cnt[pick] = load_cnt[pick] + 1'b1;
      r.status        = ST_OK;
      r.chosen_worker = WORKER_W'(pick);
      r.conn_out      = conn;
      r.worker_load   = load_cnt[pick];
    end else begin
      r.chosen_worker = rel;
      if (int'(rel) >= span) begin
        r.status = ST_RANGE;
      end else begin
        if (load_cnt[rel] != '0) load_cnt[rel] = load_cnt[rel] - 1'b1;
        r.status      = ST_OK;
        r.worker_load = load_cnt[rel];
      end
    end
    return r;
  endfunction

  function automatic void add_cfg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    plan.push_back('{ROW_CFG, idx, val, OP_DISPATCH, '0, '0, 1'b0, '0});
  endfunction

  function automatic void add_item(input logic op, input logic [CONN_W-1:0] conn,
                                   input logic [WORKER_W-1:0] rel);
    plan.push_back('{ROW_ITEM, REG_STRATEGY, '0, op, conn, rel, 1'b0, '0});
  endfunction

  function automatic void add_fixed(input logic op, input logic [CONN_W-1:0] conn,
                                    input logic [WORKER_W-1:0] rel, input res_t want);
    plan.push_back('{ROW_ITEM, REG_STRATEGY, '0, op, conn, rel, 1'b1, want});
  endfunction

  // Offers one item, with a random gap between bursts unless gaps are off.
  task automatic send_item(input logic op, input logic [CONN_W-1:0] conn,
                           input logic [WORKER_W-1:0] rel, input bit fixed, input res_t want);
    res_t predicted;
    int   gap;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 12);
        burst_left = $urandom_range(1, 24);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left--;
    end
    in_valid       <= 1'b1;
    opcode         <= op;
    conn_id        <= conn;
    release_worker <= rel;
    do @(posedge clk); while (!in_ready);
    predicted = predict_outcome(op, conn, rel);
    pending_results.push_back(fixed ? want : predicted);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_STRATEGY: model_cfg.strategy       = val[STRAT_W-1:0];
      REG_ENABLE:   model_cfg.enable         = val[0];
      REG_ACTIVE:   model_cfg.active_workers = val[ACTIVE_W-1:0];
      default: ;
    endcase
  endtask

  // Result checker.
  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected item: status %0d worker %0d", status, chosen_worker);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatch_count++;
        end
        if (chosen_worker !== want.chosen_worker) begin
          $error("chosen_worker: expected %0d, got %0d", want.chosen_worker, chosen_worker);
          mismatch_count++;
        end
        if (conn_out !== want.conn_out) begin
          $error("conn_out: expected %h, got %h", want.conn_out, conn_out);
          mismatch_count++;
        end
        if (worker_load !== want.worker_load) begin
          $error("worker_load: expected %0d, got %0d", want.worker_load, worker_load);
          mismatch_count++;
        end
      end
    end
  end

  // Receiver: segments of differing stall density, plus one long hold-off.
  initial begin
    int seg_len;
    int seg_mode;
    while (rst) @(posedge clk);
    forever begin
      seg_len  = $urandom_range(4, 60);
      seg_mode = $urandom_range(0, 3);
      repeat (seg_len) begin
        @(posedge clk);
        case (seg_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        @(posedge clk);
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  // Watchdog on cycles with no item moving on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_least_connections_dispatcher failed");
        $finish;
      end
    end
  end

  initial begin
    int                  span;
    logic [CFG_W-1:0]    active_val;
    logic                op;
    logic [WORKER_W-1:0] rel;

    for (int i = 0; i < WORKERS; i++) load_cnt[i] = '0;
    rr_next    = '0;
    least_prev = '0;
    model_cfg  = '{STRAT_LEAST, 1'b0, ACTIVE_RESET};

    // Directed table: reset state, field extremes, every mode and the corner cases.
    add_fixed(OP_DISPATCH, 32'hFFFF_FFFF, 6'd63, '{ST_DISABLED, 6'd0, 32'd0, 16'd0});
    add_fixed(OP_RELEASE, 32'hFFFF_FFFF, 6'd0, '{ST_OK, 6'd0, 32'd0, 16'd0});
    add_fixed(OP_RELEASE, 32'd0, 6'd63, '{ST_RANGE, 6'd63, 32'd0, 16'd0});
    add_fixed(OP_RELEASE, 32'd0, 6'd8, '{ST_RANGE, 6'd8, 32'd0, 16'd0});
    add_cfg(REG_ENABLE, 7'd1);
    add_fixed(OP_DISPATCH, 32'hFFFF_FFFF, 6'd0, '{ST_OK, 6'd0, 32'hFFFF_FFFF, 16'd1});
    add_fixed(OP_DISPATCH, 32'd0, 6'd63, '{ST_OK, 6'd1, 32'd0, 16'd1});
    add_item(OP_DISPATCH, 32'h5555_5555, 6'd0);
    add_fixed(OP_RELEASE, 32'hFFFF_FFFF, 6'd1, '{ST_OK, 6'd1, 32'd0, 16'd0});
    add_item(OP_DISPATCH, 32'hAAAA_AAAA, 6'd0);
    add_cfg(REG_STRATEGY, 7'(STRAT_RR));
    add_item(OP_DISPATCH, 32'h0000_0001, 6'd0);
    add_item(OP_DISPATCH, 32'h8000_0000, 6'd0);
    add_item(OP_DISPATCH, 32'h1234_5678, 6'd0);
    // Fewer workers than the round-robin pointer: the pointer restarts at zero.
    add_cfg(REG_ACTIVE, 7'd2);
    add_item(OP_DISPATCH, 32'hDEAD_BEEF, 6'd0);
    add_fixed(OP_RELEASE, 32'd0, 6'd2, '{ST_RANGE, 6'd2, 32'd0, 16'd0});
    add_cfg(REG_STRATEGY, 7'(STRAT_LEAST));
    add_item(OP_DISPATCH, 32'hCAFE_F00D, 6'd0);
    // A worker count of zero acts as one.
    add_cfg(REG_ACTIVE, 7'd0);
    add_item(OP_DISPATCH, 32'h0F0F_0F0F, 6'd0);
    add_fixed(OP_RELEASE, 32'd0, 6'd1, '{ST_RANGE, 6'd1, 32'd0, 16'd0});
    add_cfg(REG_ACTIVE, 7'h7F);
    add_item(OP_RELEASE, 32'd0, 6'd7);
    add_fixed(OP_RELEASE, 32'd0, 6'd63, '{ST_RANGE, 6'd63, 32'd0, 16'd0});
    add_cfg(REG_ACTIVE, 7'd64);
    add_item(OP_RELEASE, 32'd0, 6'd3);
    add_cfg(REG_STRATEGY, 7'(STRAT_ZERO));
    add_item(OP_DISPATCH, 32'hF0F0_F0F0, 6'd0);
    add_cfg(REG_STRATEGY, 7'(STRAT_SPARE));
    add_item(OP_DISPATCH, 32'h7FFF_FFFF, 6'd0);
    // Releases are still served while dispatching is off.
    add_cfg(REG_ENABLE, 7'd0);
    add_item(OP_RELEASE, 32'd0, 6'd0);
    add_fixed(OP_DISPATCH, 32'h1111_1111, 6'd0, '{ST_DISABLED, 6'd0, 32'd0, 16'd0});

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_CFG) begin
        wait_idle();
        write_reg(plan[k].reg_idx, plan[k].reg_val);
      end else begin
        send_item(plan[k].op, plan[k].conn, plan[k].rel, plan[k].fixed, plan[k].want);
      end
    end

    // Random phases, each under a fresh setting of all three registers.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0:       active_val = 7'd0;
        1:       active_val = 7'd1;
        2:       active_val = 7'd2;
        3:       active_val = 7'd8;
        4:       active_val = 7'd9;
        5:       active_val = 7'd64;
        6:       active_val = 7'h7F;
        default: active_val = 7'($urandom_range(1, WORKERS));
      endcase
      write_reg(REG_STRATEGY, 7'($urandom_range(0, 3)));
      write_reg(REG_ENABLE, ($urandom_range(0, 7) != 0) ? 7'd1 : 7'd0);
      write_reg(REG_ACTIVE, active_val);
      no_gaps = ($urandom_range(0, 3) == 0);
      span = worker_span();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = ($urandom_range(0, 9) < 6) ? OP_DISPATCH : OP_RELEASE;
        if ($urandom_range(0, 6) != 0) rel = 6'($urandom_range(0, span - 1));
        else rel = 6'($urandom_range(0, 63));
        send_item(op, $urandom, rel, 1'b0, '0);
      end
    end
    no_gaps = 1'b0;

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_least_connections_dispatcher passed");
    end else begin
      $display("tb_least_connections_dispatcher failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/lcd_pkg.sv
hw/rtl/lcd_count_mem.sv
hw/rtl/lcd_seq.sv
hw/rtl/least_connections_dispatcher.sv
tb/sv/tb_least_connections_dispatcher.sv
